>>> src/assert_macros.svh
// assertion macros used by three_channel_dial_smoother_unit.sv
// depends on a clock named clk and a reset named rst in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every edge out of reset
`define CHK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tcds_pkg.sv
// constants for the three-channel dial smoother
// no dependencies
`default_nettype none

package tcds_pkg;

  // defaults for the top-level parameters
  localparam int WINDOW_LENGTH_DEF = 150;
  localparam int SAMPLE_BITS_DEF   = 12;

  // fixed field widths
  localparam int CHANNELS = 3;
  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;
  localparam logic [LEVEL_W-1:0] DEAD_ZONE = 7'd5;

  // dial two span and the reciprocal used for 127 * x / span
  localparam int SPAN_W       = 12;
  localparam logic [SPAN_W-1:0] DIAL2_SPAN = 12'd2800;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP_W      = 20;
  localparam logic [RECIP_W-1:0] DIAL2_RECIP =
    RECIP_W'((64'd127 << RECIP_SHIFT) / 64'd2800);
  localparam int PROD2_W      = SPAN_W + RECIP_W;
  localparam int SCALED_W     = SPAN_W + LEVEL_W;

endpackage

`default_nettype wire

>>> src/three_channel_dial_smoother_unit.sv
// three-channel dial smoother: boxcar moving average over a sample window
// uses tcds_pkg constants and the assertion macros in assert_macros.svh
// throughput: one item per cycle unless stalled; window written and read per transfer
// stages: running sums, reciprocal product, average fix-up, level / scale, result
// reset: synchronous; fill bits, sums, position, previous levels and stage valids clear
`default_nettype none

`include "assert_macros.svh"

module three_channel_dial_smoother_unit #(
  parameter int WINDOW_LENGTH = tcds_pkg::WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = tcds_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sample_valid,
  output logic                              sample_stall,
  input  wire logic [tcds_pkg::SAMPLE_W-1:0] sample_0,
  input  wire logic [tcds_pkg::SAMPLE_W-1:0] sample_1,
  input  wire logic [tcds_pkg::SAMPLE_W-1:0] sample_2,
  output logic                              level_valid,
  input  wire logic                         level_stall,
  output logic [tcds_pkg::LEVEL_W-1:0]      level_0,
  output logic [tcds_pkg::LEVEL_W-1:0]      level_1,
  output logic [tcds_pkg::LEVEL_W-1:0]      level_2,
  output logic                              changed_0,
  output logic                              changed_1,
  output logic                              changed_2
);

  localparam int CH      = tcds_pkg::CHANNELS;
  localparam int LW      = tcds_pkg::LEVEL_W;
  localparam int POS_W   = $clog2(WINDOW_LENGTH);
  localparam int SUM_W   = SAMPLE_BITS + POS_W;
  localparam int ENTRY_W = CH * SAMPLE_BITS;
  localparam logic [SUM_W-1:0] AVG_RECIP =
    SUM_W'((64'd1 << SUM_W) / 64'(WINDOW_LENGTH));
  localparam logic [SUM_W-1:0] WIN_SUM = SUM_W'(WINDOW_LENGTH);
  localparam int EXT_W = (SAMPLE_BITS > tcds_pkg::SPAN_W) ? SAMPLE_BITS : tcds_pkg::SPAN_W;

  // pipeline control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic accept;

  // window storage and position
  logic [ENTRY_W-1:0]       win_mem [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] filled;
  logic [ENTRY_W-1:0]       rd_data;
  logic                     rd_valid;
  logic [POS_W-1:0]         pos;
  logic [POS_W-1:0]         pos_next;

  // per-channel datapath
  logic [SAMPLE_BITS-1:0] new_s   [CH];
  logic [SAMPLE_BITS-1:0] old_s   [CH];
  logic [SUM_W-1:0]       sum     [CH];
  logic [SUM_W-1:0]       sum_next[CH];
  logic [ENTRY_W-1:0]     new_entry;
  logic [SUM_W-1:0]       s2_sum  [CH];
  logic [2*SUM_W-1:0]     s2_prod [CH];
  logic [SUM_W-1:0]       q_est   [CH];
  logic [SUM_W-1:0]       rem     [CH];
  logic [SAMPLE_BITS-1:0] avg_next[CH];
  logic [SAMPLE_BITS-1:0] s3_avg  [CH];

  // stage 4 / 5 signals
  logic [EXT_W-1:0]                avg2_ext;
  logic                            sat_next;
  logic [tcds_pkg::SPAN_W-1:0]     x_next;
  logic [LW-1:0]                   s4_lvl0, s4_lvl1;
  logic                            s4_sat;
  logic [tcds_pkg::SPAN_W-1:0]     s4_x;
  logic [tcds_pkg::PROD2_W-1:0]    s4_prod2;
  logic [tcds_pkg::SCALED_W-1:0]   x127;
  logic [tcds_pkg::SCALED_W-1:0]   rem2;
  logic [LW-1:0]                   q2;
  logic [LW-1:0]                   q2_fix;
  logic [LW-1:0]                   lvl2_next;
  logic [LW-1:0]                   prev_0, prev_1, prev_2;

  // inverted level for dials zero and one, saturating at zero
  function automatic logic [LW-1:0] inv_level(input logic [SAMPLE_BITS-1:0] avg);
    logic [SAMPLE_BITS-1:0] q;
    q = avg >> 5;
    if (q >= SAMPLE_BITS'(tcds_pkg::LEVEL_MAX)) begin
      return '0;
    end
    return LW'(SAMPLE_BITS'(tcds_pkg::LEVEL_MAX) - q);
  endfunction

  // ready chain, a stage advances when empty or when the next one advances
  assign rdy5         = !level_valid || !level_stall;
  assign rdy4         = !v4 || rdy5;
  assign rdy3         = !v3 || rdy4;
  assign rdy2         = !v2 || rdy3;
  assign rdy1         = !v1 || rdy2;
  assign sample_stall = !rdy1;
  assign accept       = sample_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      level_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) level_valid <= v4;
    end
  end

  // position wraps over the window
  assign pos_next = (pos == POS_W'(WINDOW_LENGTH - 1)) ? '0 : pos + 1'b1;

  // window update: oldest sample leaves, new sample enters
  always_comb begin
    new_s[0] = SAMPLE_BITS'(sample_0);
    new_s[1] = SAMPLE_BITS'(sample_1);
    new_s[2] = SAMPLE_BITS'(sample_2);
    for (int c = 0; c < CH; c++) begin
      old_s[c]    = rd_valid ? rd_data[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      sum_next[c] = sum[c] - SUM_W'(old_s[c]) + SUM_W'(new_s[c]);
    end
    new_entry = {new_s[2], new_s[1], new_s[0]};
  end

  // window memory, the entry at the next position is prefetched on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      win_mem[pos] <= new_entry;
      rd_data      <= win_mem[pos_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled   <= '0;
      rd_valid <= 1'b0;
      pos      <= '0;
      for (int c = 0; c < CH; c++) sum[c] <= '0;
    end else if (accept) begin
      filled[pos] <= 1'b1;
      rd_valid    <= filled[pos_next];
      pos         <= pos_next;
      for (int c = 0; c < CH; c++) sum[c] <= sum_next[c];
    end
  end

  // stage 2: reciprocal product for sum / window length
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int c = 0; c < CH; c++) begin
        s2_sum[c]  <= sum[c];
        s2_prod[c] <= (2*SUM_W)'(sum[c]) * (2*SUM_W)'(AVG_RECIP);
      end
    end
  end

  // stage 3: estimate is at most one low, fix with the remainder
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      q_est[c]    = s2_prod[c][2*SUM_W-1:SUM_W];
      rem[c]      = s2_sum[c] - q_est[c] * WIN_SUM;
      avg_next[c] = (rem[c] >= WIN_SUM) ? SAMPLE_BITS'(q_est[c] + 1'b1)
                                        : SAMPLE_BITS'(q_est[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int c = 0; c < CH; c++) s3_avg[c] <= avg_next[c];
    end
  end

  // stage 4: inverted levels, dial two distance below span and its product
  assign avg2_ext = EXT_W'(s3_avg[2]);
  assign sat_next = avg2_ext >= EXT_W'(tcds_pkg::DIAL2_SPAN);
  assign x_next   = tcds_pkg::SPAN_W'(EXT_W'(tcds_pkg::DIAL2_SPAN) - avg2_ext);

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      s4_lvl0  <= inv_level(s3_avg[0]);
      s4_lvl1  <= inv_level(s3_avg[1]);
      s4_sat   <= sat_next;
      s4_x     <= x_next;
      s4_prod2 <= tcds_pkg::PROD2_W'(x_next) * tcds_pkg::PROD2_W'(tcds_pkg::DIAL2_RECIP);
    end
  end

  // stage 5: fix the scaled quotient, apply saturation and dead zone
  always_comb begin
    x127   = (tcds_pkg::SCALED_W'(s4_x) << 7) - tcds_pkg::SCALED_W'(s4_x);
    q2     = LW'(s4_prod2 >> tcds_pkg::RECIP_SHIFT);
    rem2   = x127 - tcds_pkg::SCALED_W'(q2) * tcds_pkg::SCALED_W'(tcds_pkg::DIAL2_SPAN);
    q2_fix = (rem2 >= tcds_pkg::SCALED_W'(tcds_pkg::DIAL2_SPAN)) ? q2 + 1'b1 : q2;
    if (s4_sat || (q2_fix < tcds_pkg::DEAD_ZONE)) begin
      lvl2_next = '0;
    end else begin
      lvl2_next = q2_fix;
    end
  end

  // result register and previous levels for the change flags
  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      level_0   <= s4_lvl0;
      level_1   <= s4_lvl1;
      level_2   <= lvl2_next;
      changed_0 <= (s4_lvl0 != prev_0);
      changed_1 <= (s4_lvl1 != prev_1);
      changed_2 <= (lvl2_next != prev_2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_0 <= '0;
      prev_1 <= '0;
      prev_2 <= '0;
    end else if (rdy5 && v4) begin
      prev_0 <= s4_lvl0;
      prev_1 <= s4_lvl1;
      prev_2 <= lvl2_next;
    end
  end

  // checks
  `CHK_ALWAYS(a_pos_range, pos <= POS_W'(WINDOW_LENGTH - 1), "write position out of window")
  `CHK_IMPLY(a_rd_filled, rd_valid, filled[pos], "prefetched entry marked valid but slot empty")
  `CHK_NEXT(a_fill_mark, accept, filled[$past(pos)], "written slot not marked filled")
  `CHK_IMPLY(a_dead_zone, level_valid, (level_2 == '0) || (level_2 >= tcds_pkg::DEAD_ZONE), "level two inside dead zone")

endmodule

`default_nettype wire
